// File: rtl/asl_pkg.sv
// asl_pkg: shared constants, types and helper functions for the access log splitter
// no dependencies; imported by every other file of the block
`timescale 1ns / 1ps
`default_nettype none

package asl_pkg;

    // line geometry
    localparam int LINE_BYTES = 2048;
    localparam int OFS_W      = 12;     // byte offset, holds 0..LINE_BYTES
    localparam int START_W    = 11;
    localparam int LEN_W      = 12;
    localparam int KIND_W     = 4;
    localparam int VAL_W      = 32;
    localparam int FN_W       = 4;
    localparam int ACC_W      = 32;
    localparam int PROD_W     = 36;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    // field numbers while walking the line
    localparam logic [FN_W-1:0] F_HOST     = 4'd0;
    localparam logic [FN_W-1:0] F_RUSER    = 4'd1;
    localparam logic [FN_W-1:0] F_USER     = 4'd2;
    localparam logic [FN_W-1:0] F_STATUS   = 4'd3;
    localparam logic [FN_W-1:0] F_BYTES    = 4'd4;
    localparam logic [FN_W-1:0] F_VHOST    = 4'd5;
    localparam logic [FN_W-1:0] F_REQUEST  = 4'd6;
    localparam logic [FN_W-1:0] F_REFERRER = 4'd7;
    localparam logic [FN_W-1:0] F_AGENT    = 4'd8;

    // result kinds
    localparam logic [KIND_W-1:0] K_HOST     = 4'd0;
    localparam logic [KIND_W-1:0] K_RUSER    = 4'd1;
    localparam logic [KIND_W-1:0] K_USER     = 4'd2;
    localparam logic [KIND_W-1:0] K_STATUS   = 4'd3;
    localparam logic [KIND_W-1:0] K_BYTES    = 4'd4;
    localparam logic [KIND_W-1:0] K_VHOST    = 4'd5;
    localparam logic [KIND_W-1:0] K_METHOD   = 4'd6;
    localparam logic [KIND_W-1:0] K_URI      = 4'd7;
    localparam logic [KIND_W-1:0] K_PROTOCOL = 4'd8;
    localparam logic [KIND_W-1:0] K_REFERRER = 4'd9;
    localparam logic [KIND_W-1:0] K_AGENT    = 4'd10;
    localparam logic [KIND_W-1:0] K_VERDICT  = 4'd11;

    // request sub-parts
    localparam logic [1:0] RP_METHOD   = 2'd0;
    localparam logic [1:0] RP_URI      = 2'd1;
    localparam logic [1:0] RP_PROTOCOL = 2'd2;

    // byte codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [ACC_W-1:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [ACC_W-1:0] POS_MAX   = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        NP_SKIP,
        NP_DIGITS,
        NP_STOP,
        NP_DASH
    } t_num_phase;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [START_W-1:0]      start;
        logic [LEN_W-1:0]        length;
        logic signed [VAL_W-1:0] value;
        logic                    accepted;
        logic                    last;
    } t_result;

    // one processed byte gives up to two results, res0 first
    typedef struct packed {
        logic    push0;
        logic    push1;
        t_result res0;
        t_result res1;
    } t_push;

    typedef struct packed {
        logic               room;
        logic [FIFO_CW-1:0] level;
    } t_fifo_stat;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic [KIND_W-1:0] top_kind(input logic [FN_W-1:0] f);
        logic [KIND_W-1:0] k;
        unique case (f)
            F_HOST:     k = K_HOST;
            F_RUSER:    k = K_RUSER;
            F_USER:     k = K_USER;
            F_STATUS:   k = K_STATUS;
            F_BYTES:    k = K_BYTES;
            F_VHOST:    k = K_VHOST;
            F_REQUEST:  k = K_METHOD;
            F_REFERRER: k = K_REFERRER;
            F_AGENT:    k = K_AGENT;
            default:    k = K_VERDICT;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// File: rtl/asl_if.sv
// asl_line_if / asl_field_if: valid-ready channels for line bytes and field results
// depends on asl_pkg
`timescale 1ns / 1ps
`default_nettype none

interface asl_line_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;
    logic       end_of_line;

    modport source (output valid, output line_byte, output end_of_line, input ready);
    modport sink   (input valid, input line_byte, input end_of_line, output ready);
endinterface

interface asl_field_if import asl_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       field_kind;
    logic [START_W-1:0]      field_start;
    logic [LEN_W-1:0]        field_length;
    logic signed [VAL_W-1:0] numeric_value;
    logic                    line_accepted;
    logic                    last_of_line;

    modport source (output valid, output field_kind, output field_start,
                    output field_length, output numeric_value, output line_accepted,
                    output last_of_line, input ready);
    modport sink   (input valid, input field_kind, input field_start,
                    input field_length, input numeric_value, input line_accepted,
                    input last_of_line, output ready);
endinterface

`default_nettype wire

// File: rtl/asl_parse.sv
// asl_parse: input byte register, per-line parse state and result generation
// depends on asl_pkg and asl_line_if
`timescale 1ns / 1ps
`default_nettype none

module asl_parse import asl_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    asl_line_if.sink    i_line,
    input  wire logic [7:0] i_sep,
    input  wire logic   i_room,
    output t_push       o_push
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_eol;
    logic       w_fire;
    logic       w_in_ready;

    logic [FN_W-1:0]  r_field_number, n_field_number;
    logic [1:0]       r_part, n_part;
    logic [OFS_W-1:0] r_byte_offset, n_byte_offset;
    logic [OFS_W-1:0] r_field_start, n_field_start;
    logic [OFS_W-1:0] r_part_start, n_part_start;
    logic [ACC_W-1:0] r_acc, n_acc;
    t_num_phase       r_phase, n_phase;
    logic             r_neg, n_neg;
    logic             r_failed, n_failed;

    logic [PROD_W-1:0] w_prod;
    logic [ACC_W-1:0]  w_num_value;
    logic              w_in_digits;
    logic              w_mid_valid;
    t_result           w_mid;
    logic              w_agent_valid;
    t_result           w_agent;
    t_result           w_verdict;
    logic              w_line_ok;

    assign w_fire     = r_valid && i_room;
    assign w_in_ready = !r_valid || w_fire;
    assign i_line.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_valid <= i_line.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_line.valid && w_in_ready) begin
            r_byte <= i_line.line_byte;
            r_eol  <= i_line.end_of_line;
        end
    end

    // value of the number field gathered so far
    always_comb begin
        priority if (r_phase == NP_DASH) begin
            w_num_value = '1;
        end else if (r_neg) begin
            w_num_value = ACC_W'(0) - r_acc;
        end else if (r_acc > POS_MAX) begin
            w_num_value = POS_MAX;
        end else begin
            w_num_value = r_acc;
        end
    end

    // acc * 10 + digit
    assign w_prod = (PROD_W'(r_acc) << 3) + (PROD_W'(r_acc) << 1)
                  + PROD_W'(r_byte - CH_ZERO);

    always_comb begin
        n_field_number = r_field_number;
        n_part         = r_part;
        n_byte_offset  = r_byte_offset;
        n_field_start  = r_field_start;
        n_part_start   = r_part_start;
        n_acc          = r_acc;
        n_phase        = r_phase;
        n_neg          = r_neg;
        n_failed       = r_failed;
        w_mid_valid    = 1'b0;
        w_mid          = '0;
        w_in_digits    = 1'b0;

        if (r_byte_offset >= OFS_W'(LINE_BYTES)) begin
            n_failed = 1'b1;
        end else begin
            n_byte_offset = r_byte_offset + OFS_W'(1);
            if (!r_failed && r_field_number <= F_AGENT) begin
                if (r_byte == i_sep) begin
                    if (r_field_number == F_REQUEST) begin
                        if (r_part == RP_PROTOCOL) begin
                            w_mid_valid  = 1'b1;
                            w_mid.kind   = K_PROTOCOL;
                            w_mid.start  = r_part_start[START_W-1:0];
                            w_mid.length = r_byte_offset - r_part_start;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end else begin
                        w_mid_valid  = 1'b1;
                        w_mid.kind   = top_kind(r_field_number);
                        w_mid.start  = r_field_start[START_W-1:0];
                        w_mid.length = r_byte_offset - r_field_start;
                        if (r_field_number == F_STATUS || r_field_number == F_BYTES) begin
                            w_mid.value = w_num_value;
                        end
                    end
                    n_field_number = r_field_number + FN_W'(1);
                    n_field_start  = r_byte_offset + OFS_W'(1);
                    n_part_start   = r_byte_offset + OFS_W'(1);
                    n_part         = RP_METHOD;
                    n_acc          = '0;
                    n_phase        = NP_SKIP;
                    n_neg          = 1'b0;
                end else if (r_field_number == F_REQUEST) begin
                    if (r_byte == CH_SPACE && r_part != RP_PROTOCOL) begin
                        w_mid_valid  = 1'b1;
                        w_mid.kind   = (r_part == RP_METHOD) ? K_METHOD : K_URI;
                        w_mid.start  = r_part_start[START_W-1:0];
                        w_mid.length = r_byte_offset - r_part_start;
                        n_part       = r_part + 2'd1;
                        n_part_start = r_byte_offset + OFS_W'(1);
                    end
                end else if (r_field_number == F_STATUS || r_field_number == F_BYTES) begin
                    unique case (r_phase)
                        NP_SKIP: begin
                            priority if (r_field_number == F_BYTES
                                         && r_byte_offset == r_field_start
                                         && r_byte == CH_DASH) begin
                                n_phase = NP_DASH;
                            end else if (is_space(r_byte)) begin
                                n_phase = NP_SKIP;
                            end else if (r_byte == CH_PLUS || r_byte == CH_DASH) begin
                                n_neg   = (r_byte == CH_DASH);
                                n_phase = NP_DIGITS;
                            end else begin
                                w_in_digits = 1'b1;
                            end
                        end
                        NP_DIGITS: w_in_digits = 1'b1;
                        NP_STOP:   n_phase = NP_STOP;
                        NP_DASH:   n_phase = NP_DASH;
                        default:   n_phase = r_phase;
                    endcase
                    if (w_in_digits) begin
                        if (is_digit(r_byte)) begin
                            n_phase = NP_DIGITS;
                            n_acc   = (w_prod > PROD_W'(MAG_LIMIT)) ? MAG_LIMIT
                                                                   : w_prod[ACC_W-1:0];
                        end else begin
                            n_phase = NP_STOP;
                        end
                    end
                end
            end
        end

        // end of line: optional agent, then the verdict
        w_agent_valid  = r_eol && !n_failed && n_field_number == F_AGENT
                      && n_byte_offset > n_field_start;
        w_agent        = '0;
        w_agent.kind   = K_AGENT;
        w_agent.start  = n_field_start[START_W-1:0];
        w_agent.length = n_byte_offset - n_field_start;

        w_line_ok          = !n_failed && n_field_number >= F_AGENT;
        w_verdict          = '0;
        w_verdict.kind     = K_VERDICT;
        w_verdict.length   = n_byte_offset;
        w_verdict.accepted = w_line_ok;
        w_verdict.last     = 1'b1;

        if (r_eol) begin
            n_field_number = F_HOST;
            n_part         = RP_METHOD;
            n_byte_offset  = '0;
            n_field_start  = '0;
            n_part_start   = '0;
            n_acc          = '0;
            n_phase        = NP_SKIP;
            n_neg          = 1'b0;
            n_failed       = 1'b0;
        end
    end

    // mid-line and agent results never occur on the same byte
    always_comb begin
        o_push       = '0;
        o_push.push0 = w_fire && (w_mid_valid || w_agent_valid || r_eol);
        o_push.push1 = w_fire && (w_mid_valid || w_agent_valid) && r_eol;
        priority if (w_mid_valid) begin
            o_push.res0 = w_mid;
        end else if (w_agent_valid) begin
            o_push.res0 = w_agent;
        end else begin
            o_push.res0 = w_verdict;
        end
        o_push.res1 = w_verdict;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_number <= F_HOST;
            r_part         <= RP_METHOD;
            r_byte_offset  <= '0;
            r_field_start  <= '0;
            r_part_start   <= '0;
            r_acc          <= '0;
            r_phase        <= NP_SKIP;
            r_neg          <= 1'b0;
            r_failed       <= 1'b0;
        end else if (w_fire) begin
            r_field_number <= n_field_number;
            r_part         <= n_part;
            r_byte_offset  <= n_byte_offset;
            r_field_start  <= n_field_start;
            r_part_start   <= n_part_start;
            r_acc          <= n_acc;
            r_phase        <= n_phase;
            r_neg          <= n_neg;
            r_failed       <= n_failed;
        end
    end

endmodule

`default_nettype wire

// File: rtl/asl_rfifo.sv
// asl_rfifo: small result queue, two writes and one read per cycle
// depends on asl_pkg and asl_field_if
`timescale 1ns / 1ps
`default_nettype none

module asl_rfifo import asl_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_push  i_push,
    output t_fifo_stat  o_stat,
    asl_field_if.source o_field
);

    t_result            r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr, n_wr;
    logic [FIFO_AW-1:0] r_rd, n_rd;
    logic [FIFO_CW-1:0] r_count, n_count;
    logic               w_pop;
    t_result            w_head;

    assign w_pop  = o_field.valid && o_field.ready;
    assign w_head = r_mem[r_rd];

    assign o_field.valid         = (r_count != '0);
    assign o_field.field_kind    = w_head.kind;
    assign o_field.field_start   = w_head.start;
    assign o_field.field_length  = w_head.length;
    assign o_field.numeric_value = w_head.value;
    assign o_field.line_accepted = w_head.accepted;
    assign o_field.last_of_line  = w_head.last;

    // room for a full two-result push regardless of the read side
    assign o_stat.room  = (r_count <= FIFO_CW'(FIFO_DEPTH - 2));
    assign o_stat.level = r_count;

    always_comb begin
        n_wr    = r_wr + FIFO_AW'(i_push.push0) + FIFO_AW'(i_push.push1);
        n_rd    = r_rd + FIFO_AW'(w_pop);
        n_count = r_count + FIFO_CW'(i_push.push0) + FIFO_CW'(i_push.push1)
                - FIFO_CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.push1) begin
            r_mem[r_wr + FIFO_AW'(1)] <= i_push.res1;
        end
    end

endmodule

`default_nettype wire

// File: rtl/access_log_line_field_splitter.sv
// access log line field splitter: one line byte per beat in, one field per beat out
// an accepted byte waits in the byte register, then its results are written into the result queue
// throughput: one byte per cycle; the closing byte can give two results, drained at one per cycle
// the byte stage moves only while the 4-entry result queue has room for two entries
// reset: synchronous active low, clears parse state and queue, separator returns to tab
// depends on asl_pkg, asl_if, asl_parse, asl_rfifo
`timescale 1ns / 1ps
`default_nettype none

module access_log_line_field_splitter import asl_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    asl_line_if.sink        i_line,
    asl_field_if.source     o_field,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata
);

    // field separator register, tab after reset
    logic [7:0] r_sep;
    t_push      w_push;
    t_fifo_stat w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep <= CH_TAB;
        end else if (i_cfg_we) begin
            r_sep <= i_cfg_wdata;
        end
    end

    // byte register plus per-line state; turns each byte into 0..2 results
    asl_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_line  (i_line),
        .i_sep   (r_sep),
        .i_room  (w_stat.room),
        .o_push  (w_push)
    );

    // result queue decouples the byte side from the field side
    asl_rfifo u_rfifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_stat  (w_stat),
        .o_field (o_field)
    );

    // a second result in one cycle is always the verdict closing the line
    a_second_is_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.push1 |-> (w_push.push0 && w_push.res1.last
                          && w_push.res1.kind == K_VERDICT))
        else $error("second result of a byte is not the verdict");

    // a push only happens when the queue had room for both entries
    a_push_with_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.push0 |-> w_stat.room)
        else $error("result pushed without queue room");

    // queue level never passes its depth
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.level <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overflow");

    // only a verdict beat can carry the accept flag
    a_accept_on_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_field.valid && o_field.line_accepted) |-> o_field.last_of_line)
        else $error("accept flag outside verdict");

endmodule

`default_nettype wire

// File: test/tb.sv
// tb: self-checking bench for the access log line field splitter
// drives log lines byte by byte, predicts every field and verdict beat and checks them in order
// depends on asl_pkg, asl_if and the splitter rtl
`timescale 1ns / 1ps

module tb;
    import asl_pkg::*;

    // expected field beats, worked out from each accepted line byte
    class field_scoreboard;
        t_result           fields_due[$];
        logic [7:0]        separator;
        int                field_no;
        int                req_piece;
        int                line_pos;
        int                fld_begin;
        int                piece_begin;
        logic [31:0]       magnitude;
        t_num_phase        num_phase;
        bit                minus;
        bit                line_bad;
        int                n_errors;
        int                n_checked;
        int                n_lines;
        int                n_good_lines;
        logic [KIND_W-1:0] kind_of_field[9];

        function new();
            kind_of_field = '{K_HOST, K_RUSER, K_USER, K_STATUS, K_BYTES, K_VHOST,
                              K_METHOD, K_REFERRER, K_AGENT};
            separator = CH_TAB;
            restart_line();
        endfunction

        function void restart_line();
            field_no    = int'(F_HOST);
            req_piece   = int'(RP_METHOD);
            line_pos    = 0;
            fld_begin   = 0;
            piece_begin = 0;
            magnitude   = '0;
            num_phase   = NP_SKIP;
            minus       = 1'b0;
            line_bad    = 1'b0;
        endfunction

        function void set_separator(logic [7:0] s);
            separator = s;
        endfunction

        function int pending();
            return fields_due.size();
        endfunction

        function void expect_field(logic [KIND_W-1:0] kind, int start, int len,
                                   logic [31:0] val, bit acc, bit last);
            t_result r;
            r.kind     = kind;
            r.start    = START_W'(start);
            r.length   = LEN_W'(len);
            r.value    = val;
            r.accepted = acc;
            r.last     = last;
            fields_due.push_back(r);
        endfunction

        // atoi-like digest of one status or bytes character
        function void absorb_number_char(logic [7:0] b, bit first, bit is_bytes);
            longint unsigned m;
            if (num_phase == NP_SKIP) begin
                if (is_bytes && first && b == CH_DASH) begin
                    num_phase = NP_DASH;
                    return;
                end
                if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))
                    return;
                if (b == CH_PLUS || b == CH_DASH) begin
                    minus     = (b == CH_DASH);
                    num_phase = NP_DIGITS;
                    return;
                end
                num_phase = NP_DIGITS;
            end
            if (num_phase == NP_DIGITS) begin
                if (b >= CH_ZERO && b <= CH_NINE) begin
                    m = 64'(magnitude) * 64'd10 + 64'(b - CH_ZERO);
                    magnitude = (m > 64'(MAG_LIMIT)) ? MAG_LIMIT : m[31:0];
                end else begin
                    num_phase = NP_STOP;
                end
            end
        endfunction

        function logic [31:0] parsed_number();
            if (num_phase == NP_DASH)
                return 32'hFFFF_FFFF;
            if (minus)
                return 32'd0 - magnitude;
            return (magnitude > POS_MAX) ? POS_MAX : magnitude;
        endfunction

        function void note_byte(logic [7:0] b, bit eol);
            int          off;
            logic [31:0] v;
            bit          ok;
            if (line_pos >= LINE_BYTES) begin
                line_bad = 1'b1;
            end else begin
                off = line_pos;
                line_pos++;
                if (!line_bad && field_no <= int'(F_AGENT)) begin
                    if (b == separator) begin
                        if (field_no == int'(F_REQUEST)) begin
                            if (req_piece == int'(RP_PROTOCOL))
                                expect_field(K_PROTOCOL, piece_begin, off - piece_begin,
                                             '0, 1'b0, 1'b0);
                            else
                                line_bad = 1'b1;
                        end else begin
                            v = (field_no == int'(F_STATUS) || field_no == int'(F_BYTES)) ?
                                parsed_number() : '0;
                            expect_field(kind_of_field[field_no], fld_begin, off - fld_begin,
                                         v, 1'b0, 1'b0);
                        end
                        field_no++;
                        fld_begin   = off + 1;
                        piece_begin = off + 1;
                        req_piece   = int'(RP_METHOD);
                        magnitude   = '0;
                        num_phase   = NP_SKIP;
                        minus       = 1'b0;
                    end else if (field_no == int'(F_REQUEST)) begin
                        if (b == CH_SPACE && req_piece < int'(RP_PROTOCOL)) begin
                            expect_field(req_piece == int'(RP_METHOD) ? K_METHOD : K_URI,
                                         piece_begin, off - piece_begin, '0, 1'b0, 1'b0);
                            req_piece++;
                            piece_begin = off + 1;
                        end
                    end else if (field_no == int'(F_STATUS) || field_no == int'(F_BYTES)) begin
                        absorb_number_char(b, off == fld_begin, field_no == int'(F_BYTES));
                    end
                end
            end
            if (eol) begin
                if (!line_bad && field_no == int'(F_AGENT) && line_pos > fld_begin)
                    expect_field(K_AGENT, fld_begin, line_pos - fld_begin, '0, 1'b0, 1'b0);
                ok = !line_bad && field_no >= int'(F_AGENT);
                expect_field(K_VERDICT, 0, line_pos, '0, ok, 1'b1);
                n_lines++;
                if (ok)
                    n_good_lines++;
                restart_line();
            end
        endfunction

        function void report_field(string what, longint want, longint got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
                n_errors++;
            end
        endfunction

        function void check_field(t_result got);
            t_result want;
            if (fields_due.size() == 0) begin
                $display("%0t: unexpected field beat, expected none, actual kind %0d start %0d len %0d",
                         $time, got.kind, got.start, got.length);
                n_errors++;
                return;
            end
            want = fields_due.pop_front();
            n_checked++;
            report_field("field_kind", longint'(want.kind), longint'(got.kind));
            report_field("field_start", longint'(want.start), longint'(got.start));
            report_field("field_length", longint'(want.length), longint'(got.length));
            report_field("numeric_value", longint'(want.value), longint'(got.value));
            report_field("line_accepted", longint'(want.accepted), longint'(got.accepted));
            report_field("last_of_line", longint'(want.last), longint'(got.last));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [7:0] cfg_wdata;

    asl_line_if  line_ch ();
    asl_field_if field_ch ();

    access_log_line_field_splitter u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_line      (line_ch),
        .o_field     (field_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    field_scoreboard sb = new();

    logic [7:0] line_buf[$];          // line being assembled before it is sent
    logic [7:0] cur_sep = CH_TAB;     // separator the generators steer around
    bit         idle_on = 1'b1;       // random idling allowed on both sides
    bit         sender_gaps;
    int         bytes_sent;
    int         seps_used;
    t_result    got;

    // 2 ns clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // hard stop in case the block hangs
    initial begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // result side: ready changes on the falling edge, in stretches that
    // either stall in random bursts or stay calm
    initial begin
        int stall_left;
        int stretch_left;
        bit calm;
        field_ch.ready = 1'b0;
        stall_left   = 0;
        stretch_left = 0;
        calm         = 1'b0;
        forever begin
            @(negedge clk);
            if (stretch_left == 0) begin
                stretch_left = $urandom_range(20, 200);
                calm = ($urandom_range(0, 2) == 0);
            end
            stretch_left--;
            if (stall_left > 0) begin
                stall_left--;
                field_ch.ready <= 1'b0;
            end else if (idle_on && !calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 12) - 1;
                field_ch.ready <= 1'b0;
            end else begin
                field_ch.ready <= 1'b1;
            end
        end
    end

    // every accepted result beat is checked against the oldest expectation
    always @(posedge clk) begin
        if (rst_n && field_ch.valid && field_ch.ready) begin
            got.kind     = field_ch.field_kind;
            got.start    = field_ch.field_start;
            got.length   = field_ch.field_length;
            got.value    = field_ch.numeric_value;
            got.accepted = field_ch.line_accepted;
            got.last     = field_ch.last_of_line;
            sb.check_field(got);
        end
    end

    // one line beat; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input bit eol);
        int gap;
        if (sender_gaps && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 12);
            line_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        line_ch.valid       <= 1'b1;
        line_ch.line_byte   <= b;
        line_ch.end_of_line <= eol;
        @(posedge clk);
        while (!line_ch.ready)
            @(posedge clk);
        sb.note_byte(b, eol);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_line();
        sender_gaps = idle_on && ($urandom_range(0, 2) != 0);
        for (int i = 0; i < line_buf.size(); i++)
            send_byte(line_buf[i], i == line_buf.size() - 1);
    endtask

    // hold the sender until every expected beat is back, then let the pipe settle
    task automatic wait_drained();
        line_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    // register write, only while the block is idle
    task automatic write_separator(input logic [7:0] s);
        cfg_we    <= 1'b1;
        cfg_wdata <= s;
        @(posedge clk);
        sb.set_separator(s);
        cur_sep = s;
        seps_used++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // content byte that never equals the separator
    function automatic logic [7:0] any_byte(bit no_space);
        logic [7:0] b;
        do begin
            if ($urandom_range(0, 4) != 0)
                b = 8'($urandom_range(33, 126));
            else
                b = 8'($urandom_range(0, 255));
        end while (b == cur_sep || (no_space && b == CH_SPACE));
        return b;
    endfunction

    function automatic void put_char(logic [7:0] b);
        if (b != cur_sep)
            line_buf.push_back(b);
    endfunction

    function automatic void put_text(int n, bit no_space);
        repeat (n) line_buf.push_back(any_byte(no_space));
    endfunction

    function automatic void put_string(string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endfunction

    function automatic void put_digits(int n);
        repeat (n) put_char(8'(CH_ZERO + $urandom_range(0, 9)));
    endfunction

    function automatic void put_blank(int n);
        repeat (n) put_char(($urandom_range(0, 5) == 0) ? CH_SPACE : 8'($urandom_range(9, 13)));
    endfunction

    function automatic void put_sign();
        put_char(($urandom_range(0, 1) != 0) ? CH_DASH : CH_PLUS);
    endfunction

    // mostly short fields, now and then a longer one
    function automatic int field_len();
        return ($urandom_range(0, 9) != 0) ? $urandom_range(0, 6) : $urandom_range(7, 40);
    endfunction

    // status / bytes text: plain, padded, signed, saturating, dash, junk, empty, double sign
    function automatic void put_number();
        case ($urandom_range(0, 9))
            0, 1, 2: put_digits($urandom_range(1, 4));
            3: begin
                put_blank($urandom_range(1, 3));
                if ($urandom_range(0, 1) != 0)
                    put_sign();
                put_digits($urandom_range(1, 5));
            end
            4: begin
                if ($urandom_range(0, 1) != 0)
                    put_sign();
                put_digits($urandom_range(9, 14));
            end
            5: begin
                put_char(CH_DASH);
                put_digits($urandom_range(0, 3));
            end
            6: begin
                put_digits($urandom_range(1, 3));
                put_text(1, 1'b0);
                put_digits($urandom_range(1, 3));
            end
            7: ;
            8: begin
                put_sign();
                put_sign();
                put_digits($urandom_range(1, 3));
            end
            default: put_text(field_len(), 1'b0);
        endcase
    endfunction

    // well-formed line with random content
    function automatic void build_line();
        line_buf.delete();
        repeat (3) begin
            put_text(field_len(), 1'b0);
            line_buf.push_back(cur_sep);
        end
        repeat (2) begin
            put_number();
            line_buf.push_back(cur_sep);
        end
        put_text(field_len(), 1'b0);
        line_buf.push_back(cur_sep);
        // request: method, space, uri, space, protocol (may hold spaces)
        put_text(field_len(), 1'b1);
        line_buf.push_back(CH_SPACE);
        put_text(field_len(), 1'b1);
        line_buf.push_back(CH_SPACE);
        put_text(field_len(), 1'b0);
        line_buf.push_back(cur_sep);
        put_text(field_len(), 1'b0);
        line_buf.push_back(cur_sep);
        // agent: empty, plain, or with trailing junk past another separator
        case ($urandom_range(0, 5))
            0: ;
            1: begin
                put_text(field_len(), 1'b0);
                line_buf.push_back(cur_sep);
                put_text(field_len(), 1'b0);
            end
            default: put_text(field_len(), 1'b0);
        endcase
    endfunction

    // damage a built line: cut, drop, stray separator, stray byte, or pure noise
    function automatic void break_line();
        int pos;
        pos = $urandom_range(0, line_buf.size() - 1);
        case ($urandom_range(0, 4))
            0: while (line_buf.size() > pos + 1) void'(line_buf.pop_back());
            1: line_buf.delete(pos);
            2: line_buf[pos] = cur_sep;
            3: line_buf[pos] = 8'($urandom);
            default: begin
                line_buf.delete();
                repeat ($urandom_range(1, 30))
                    line_buf.push_back(($urandom_range(0, 3) == 0) ? cur_sep : 8'($urandom));
            end
        endcase
        if (line_buf.size() == 0)
            line_buf.push_back(8'($urandom));
    endfunction

    task automatic directed_line(input string s);
        line_buf.delete();
        put_string(s);
        send_line();
    endtask

    task automatic single_byte_line(input logic [7:0] b);
        line_buf.delete();
        line_buf.push_back(b);
        send_line();
    endtask

    task automatic padded_line(input int total);
        line_buf.delete();
        put_string("h\tr\tu\t200\t0\tv\tG / P\tr\t");
        while (line_buf.size() < total)
            line_buf.push_back(any_byte(1'b0));
        send_line();
    endtask

    initial begin
        int phase_start;
        logic [7:0] sep_pick;

        line_ch.valid       = 1'b0;
        line_ch.line_byte   = '0;
        line_ch.end_of_line = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        rst_n               = 1'b0;
        bytes_sent          = 0;
        seps_used           = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed lines on the reset separator (tab)
        // all fields empty (the request holds only two spaces), agent empty at line end
        directed_line("\t\t\t\t\t\t  \t\t");
        directed_line("1.2.3.4\t-\tbob\t200\t1234\tvh.example\tGET /index.html HTTP/1.0\thttp://r/\tMozilla/5.0 (X)");
        // padded positive max, saturating bytes, spaced protocol, junk after agent
        directed_line("h\t-\t-\t \013+2147483647\t99999999999\tv\tPOST /a HTTP/1.1 extra words\t-\tagent\twith\textra");
        // most negative status, padded negative bytes
        directed_line("h\tr\tu\t-2147483648\t -5\tv\tA B C\tr\ta");
        // negative saturation, bytes field that is just a dash
        directed_line("h\tr\tu\t-99999999999\t-\tv\tA B C\tr\ta");
        // status just above max clamps, request with only one space
        directed_line("h\tr\tu\t2147483648\t+x7\tv\tA B\tr\ta");
        // request with no space at all
        directed_line("h\tr\tu\t1\t2\tv\tGET/nospace\tr\ta");
        // zero byte stops the status conversion
        line_buf.delete();
        put_string("h\tr\tu\t12");
        line_buf.push_back(8'h00);
        put_string("3\t0\tv\tG / P\tr\ta");
        send_line();
        // high-bit content bytes
        line_buf.delete();
        line_buf.push_back(8'hFF);
        line_buf.push_back(8'h80);
        put_string("\t\t\t7\t8\t\tM U P\t\t");
        line_buf.push_back(8'h7F);
        send_line();
        single_byte_line(8'hFF);
        single_byte_line(8'h00);
        single_byte_line(CH_TAB);
        // line that stops in the remote user field, after the host
        directed_line("host\tr");
        // overlong line, runs past the last byte slot
        padded_line(LINE_BYTES + 12);

        // separator extremes: space, zero, all ones
        wait_drained();
        write_separator(CH_SPACE);
        build_line();
        send_line();
        directed_line("h r u 1 2 v G / P r a");
        wait_drained();
        write_separator(8'h00);
        build_line();
        send_line();
        wait_drained();
        write_separator(8'hFF);
        build_line();
        send_line();

        // random part: several separator settings, last one without idling
        for (int ph = 0; ph < 6; ph++) begin
            wait_drained();
            if (ph == 5) begin
                idle_on = 1'b0;
                sep_pick = CH_TAB;
            end else begin
                case ($urandom_range(0, 5))
                    0: sep_pick = CH_TAB;
                    1: sep_pick = CH_SPACE;
                    2: sep_pick = 8'h00;
                    3: sep_pick = 8'hFF;
                    4: sep_pick = 8'h7C;
                    default: sep_pick = 8'($urandom_range(0, 255));
                endcase
            end
            write_separator(sep_pick);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < 150) begin
                // now and then the sender holds off until the results are all back
                if ($urandom_range(0, 14) == 0)
                    wait_drained();
                build_line();
                if ($urandom_range(0, 99) >= 75)
                    break_line();
                send_line();
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        $display("covered %0d line bytes in %0d lines (%0d well formed) over %0d separator settings",
                 bytes_sent, sb.n_lines, sb.n_good_lines, seps_used + 1);
        $display("checked %0d field beats, %0d mismatches", sb.n_checked, sb.n_errors);
        if (sb.n_errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
